// File: hw/rtl/epls_pkg.sv
package epls_pkg;

	localparam int LIDAR_W = 16;
	localparam int TS_W = 32;
	localparam int POS_W = 32;
	localparam int HEIGHT_W = 24;
	localparam int CONF_W = 9;
	localparam int FRAC_W = 8;
	localparam int PCNT_W = 3;

	localparam int WINDOW_DEF = 3;
	localparam logic [PCNT_W-1:0] CONF_STEPS = 3'd5;
	localparam logic [CONF_W-1:0] CONF_FULL = 9'd256;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_DONE
	} epls_state_t;

	typedef struct packed {
		logic take;
		logic start;
		logic step;
		logic load_out;
	} epls_cmd_t;

	typedef struct packed {
		logic div_done;
	} epls_sts_t;

	// count * 256 / 5, truncated, full scale from the fifth point on
	function automatic logic [CONF_W-1:0] conf_of(input logic [PCNT_W-1:0] cnt);
		logic [CONF_W-1:0] val;
		case (cnt)
			3'd0: val = 9'd0;
			3'd1: val = 9'd51;
			3'd2: val = 9'd102;
			3'd3: val = 9'd153;
			3'd4: val = 9'd204;
			default: val = CONF_FULL;
		endcase
		return val;
	endfunction

endpackage

// File: hw/rtl/epls_sample_if.sv
interface epls_sample_if;
	logic valid;
	logic ready;
	logic encoder_level;
	logic [epls_pkg::LIDAR_W-1:0] lidar_sample;
	logic [epls_pkg::TS_W-1:0] time_stamp;

	modport source (output valid, output encoder_level, output lidar_sample,
		output time_stamp, input ready);
	modport sink (input valid, input encoder_level, input lidar_sample,
		input time_stamp, output ready);
endinterface

// File: hw/rtl/epls_point_if.sv
interface epls_point_if;
	logic valid;
	logic ready;
	logic [epls_pkg::TS_W-1:0] out_time_stamp;
	logic [epls_pkg::POS_W-1:0] position_x;
	logic [epls_pkg::HEIGHT_W-1:0] surface_height;
	logic [epls_pkg::CONF_W-1:0] confidence;

	modport source (output valid, output out_time_stamp, output position_x,
		output surface_height, output confidence, input ready);
	modport sink (input valid, input out_time_stamp, input position_x,
		input surface_height, input confidence, output ready);
endinterface

// File: hw/rtl/epls_ctrl.sv
module epls_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output epls_pkg::epls_cmd_t  cmd,
	input  epls_pkg::epls_sts_t  sts
);
	import epls_pkg::*;

	epls_state_t state_q;
	epls_state_t state_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_START;
			end
			ST_START: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.take = (state_q == ST_IDLE) && in_valid;
		cmd.start = (state_q == ST_START);
		cmd.step = (state_q == ST_DIV) && !sts.div_done;
		cmd.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// a result reaches the output register once and shows valid next cycle
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result loaded but output not valid");
	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.load_out)
		else $error("pending result overwritten");
	// an accepted request always starts the divider next
	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> cmd.start)
		else $error("accepted request did not start divide");
`endif
endmodule

// File: hw/rtl/epls_dp.sv
module epls_dp #(
	parameter int WINDOW = epls_pkg::WINDOW_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  epls_pkg::epls_cmd_t               cmd,
	output epls_pkg::epls_sts_t               sts,
	input  logic                              encoder_level,
	input  logic [epls_pkg::LIDAR_W-1:0]      lidar_sample,
	input  logic [epls_pkg::TS_W-1:0]         time_stamp,
	output logic [epls_pkg::TS_W-1:0]         out_time_stamp,
	output logic [epls_pkg::POS_W-1:0]        position_x,
	output logic [epls_pkg::HEIGHT_W-1:0]     surface_height,
	output logic [epls_pkg::CONF_W-1:0]       confidence
);
	import epls_pkg::*;

	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = LIDAR_W + FILL_W;
	localparam int DIV_W = SUM_W + FRAC_W;
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [LIDAR_W-1:0] win_q [WINDOW];
	logic [SUM_W-1:0] sum_q;
	logic [FILL_W-1:0] fill_q;
	logic [SLOT_W-1:0] slot_q;
	logic first_q;
	logic last_enc_q;
	logic [POS_W-1:0] travel_q;
	logic [PCNT_W-1:0] pcnt_q;
	logic [TS_W-1:0] ts_q;

	logic [DIV_W-1:0] quo_q;
	logic [FILL_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;

	logic full;
	logic [SUM_W-1:0] sum_d;
	logic [FILL_W:0] rem_sh;
	logic rem_ge;

	logic [TS_W-1:0] ts_out_q;
	logic [POS_W-1:0] pos_out_q;
	logic [HEIGHT_W-1:0] height_out_q;
	logic [CONF_W-1:0] conf_out_q;

	assign full = (fill_q == FILL_W'(WINDOW));
	assign sum_d = sum_q - (full ? SUM_W'(win_q[slot_q]) : SUM_W'(0))
		+ SUM_W'(lidar_sample);

	// state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			fill_q <= '0;
			slot_q <= '0;
			first_q <= 1'b1;
			last_enc_q <= 1'b0;
			travel_q <= '0;
			pcnt_q <= '0;
		end else if (cmd.take) begin
			first_q <= 1'b0;
			last_enc_q <= encoder_level;
			if (!first_q && (encoder_level != last_enc_q)) travel_q <= travel_q + 1'b1;
			sum_q <= sum_d;
			if (!full) fill_q <= fill_q + 1'b1;
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			if (pcnt_q < CONF_STEPS) pcnt_q <= pcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			win_q[slot_q] <= lidar_sample;
			ts_q <= time_stamp;
		end
	end

	// restoring divide of sum * 256 by the fill, one quotient bit per cycle
	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, fill_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= {sum_q, FRAC_W'(0)};
			rem_q <= '0;
		end else if (cmd.step) begin
			quo_q <= {quo_q[DIV_W-2:0], rem_ge};
			rem_q <= rem_ge ? FILL_W'(rem_sh - {1'b0, fill_q}) : rem_sh[FILL_W-1:0];
		end
	end

	assign sts.div_done = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			ts_out_q <= ts_q;
			pos_out_q <= travel_q;
			height_out_q <= quo_q[HEIGHT_W-1:0];
			conf_out_q <= conf_of(pcnt_q);
		end
	end

	assign out_time_stamp = ts_out_q;
	assign position_x = pos_out_q;
	assign surface_height = height_out_q;
	assign confidence = conf_out_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("window fill beyond window size");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (fill_q != '0))
		else $error("divide started with empty window");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (cnt_q == CNT_W'(DIV_W)))
		else $error("divide counter not loaded");
`endif
endmodule

// File: hw/rtl/encoder_position_lidar_smoother.sv
// Encoder position and lidar smoother. Each request on sample carries an
// encoder level, a 16-bit lidar range and a timestamp, and yields exactly one
// request on point. The first sample after reset only latches the encoder
// level; every later change of level advances a 32-bit position that wraps.
// Lidar values go into a ring of the last WINDOW samples with a running sum;
// surface_height is the mean over the samples held so far, unsigned 16.8
// fixed point, truncated. confidence ramps 51, 102, 153, 204 and then
// holds at 256 (1.0). The timestamp passes through. One sample is in work at
// a time: the mean comes from a restoring divider that makes one quotient bit
// per cycle of a 16 + clog2(WINDOW+1) + 8 bit quotient. A sample is accepted,
// loaded into the divider, divided until the divide counter reaches zero and
// then loaded into the output register. A finished point sits in an output
// register, so the next sample is taken while the point waits for ready.
module encoder_position_lidar_smoother #(
	parameter int WINDOW = epls_pkg::WINDOW_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	epls_sample_if.sink   sample,
	epls_point_if.source  point
);
	import epls_pkg::*;

	epls_cmd_t cmd;
	epls_sts_t sts;
	logic in_ready;
	logic out_valid;

	// sequence accept, divide and hand-off
	epls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (point.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// window, position, divider and output register
	epls_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.encoder_level  (sample.encoder_level),
		.lidar_sample   (sample.lidar_sample),
		.time_stamp     (sample.time_stamp),
		.out_time_stamp (point.out_time_stamp),
		.position_x     (point.position_x),
		.surface_height (point.surface_height),
		.confidence     (point.confidence)
	);

	assign sample.ready = in_ready;
	assign point.valid = out_valid;
endmodule
